// ===== sv/lgru_pkg.sv =====
// shared types, constants and the cell rule for the raster-order life grid
`default_nettype none

package lgru_pkg;

  // row width and row address width set by the item fields
  localparam int ROW_W  = 16;
  localparam int ROW_AW = 4;

  // item kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  // neighbor counts that the rule looks at
  localparam logic [3:0] N_SURVIVE = 4'd2;
  localparam logic [3:0] N_BIRTH   = 4'd3;

  typedef struct packed {
    logic              kind;
    logic [ROW_AW-1:0] row_index;
    logic [ROW_W-1:0]  row_cells;
  } in_word_t;

  typedef struct packed {
    logic [ROW_AW-1:0] out_row;
    logic [ROW_W-1:0]  out_cells;
    logic              last_row;
    logic              any_changed;
  } out_word_t;

  // next state of one cell from its state and live neighbor count
  function automatic logic cell_next(input logic alive, input logic [3:0] n);
    cell_next = alive ? ((n == N_SURVIVE) || (n == N_BIRTH)) : (n == N_BIRTH);
  endfunction

endpackage

`default_nettype wire

// ===== sv/lgru_row_calc.sv =====
// new cells of one row from the new row above, the old row and the old row below
`default_nettype none

module lgru_row_calc (
  input  wire logic [lgru_pkg::ROW_W-1:0] above,
  input  wire logic [lgru_pkg::ROW_W-1:0] old_row,
  input  wire logic [lgru_pkg::ROW_W-1:0] below,
  input  wire logic [lgru_pkg::ROW_W-1:0] row_mask,
  output logic      [lgru_pkg::ROW_W-1:0] fresh
);
  import lgru_pkg::*;

  logic [ROW_W+1:0] a_x;
  logic [ROW_W+1:0] b_x;
  logic [ROW_W:0]   o_x;
  logic [ROW_W-1:0] cand0;
  logic [ROW_W-1:0] cand1;
  logic [ROW_W:0]   chain;
  logic [3:0]       n_base;

  // per column: both outcomes, for a dead and for a live new left neighbor
  always_comb begin
    a_x   = {1'b0, above, 1'b0};
    b_x   = {1'b0, below, 1'b0};
    o_x   = {1'b0, old_row};
    cand0 = '0;
    cand1 = '0;
    for (int c = 0; c < ROW_W; c++) begin
      n_base = 4'(a_x[c]) + 4'(a_x[c+1]) + 4'(a_x[c+2])
             + 4'(b_x[c]) + 4'(b_x[c+1]) + 4'(b_x[c+2])
             + 4'(o_x[c+1]);
      cand0[c] = cell_next(old_row[c], n_base);
      cand1[c] = cell_next(old_row[c], n_base + 4'd1);
    end
  end

  // select chain along the row, left cell new value picks the outcome
  always_comb begin
    chain[0] = 1'b0;
    for (int c = 0; c < ROW_W; c++) begin
      chain[c+1] = chain[c] ? cand1[c] : cand0[c];
    end
  end

  assign fresh = chain[ROW_W:1] & row_mask;

endmodule

`default_nettype wire

// ===== sv/life_grid_raster_update.sv =====
// top level: life grid kept in a row memory, stepped one row per cycle
//
// Input words are taken at a clock edge with start high and busy low.
// A load word (kind 0) writes one grid row in that cycle; rows at or beyond
// the grid size are ignored and columns beyond it are dropped. busy stays low.
// A step word (kind 1) computes one generation in raster order: the row
// memory is read one row per cycle, each new row is built from the new row
// above, the old row and the old row below, and written back in place.
// busy is high from the step word until the bottom row is written back (one
// read per row, the read latency, then the bottom row), so no word is taken
// while a step runs.
// out_valid pulses once per row, in row order, registered from each computed
// row; the bottom row carries last_row and any_changed.
// Results are shown for one cycle only; the receiver cannot stall them.
// Reset empties the grid (all cells dead) through a per-row valid bit.
`default_nettype none

module life_grid_raster_update #(
  parameter int GRID_SIZE = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire lgru_pkg::in_word_t  in_word,
  output logic                     out_valid,
  output lgru_pkg::out_word_t      out_word
);
  import lgru_pkg::*;

  localparam int GRID_USED = (GRID_SIZE > ROW_W) ? ROW_W : ((GRID_SIZE < 1) ? 1 : GRID_SIZE);
  localparam logic [ROW_W-1:0]  ROW_MASK = {ROW_W{1'b1}} >> (ROW_W - GRID_USED);
  localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(GRID_USED - 1);
  localparam logic [ROW_AW:0]   ROW_CNT  = (ROW_AW + 1)'(GRID_USED);

  typedef enum logic {ST_IDLE, ST_STEP} state_t;

  state_t            state_r;
  logic [ROW_AW:0]   rd_cnt_r;
  logic              rd_vld_r;
  logic [ROW_AW-1:0] rd_row_r;
  logic              tail_r;
  logic [ROW_W-1:0]  rd_data_r;
  logic              rd_ok_r;
  logic [ROW_W-1:0]  cur_old_r;
  logic [ROW_W-1:0]  prev_new_r;
  logic [ROW_AW-1:0] cmp_row_r;
  logic              chg_r;
  logic [ROW_W-1:0]  row_vld_r;
  logic              out_valid_r;
  out_word_t         out_word_r;

  logic [ROW_W-1:0]  mem [ROW_W];

  logic              accept;
  logic              load_we;
  logic              reading;
  logic              calc_en;
  logic [ROW_W-1:0]  rd_row_data;
  logic [ROW_W-1:0]  below;
  logic [ROW_W-1:0]  fresh;
  logic              row_chg;
  logic              mem_we;
  logic [ROW_AW-1:0] mem_waddr;
  logic [ROW_W-1:0]  mem_wdata;

  // handshake and sequencing terms
  assign busy        = (state_r != ST_IDLE);
  assign accept      = start && !busy;
  assign load_we     = accept && (in_word.kind == KIND_LOAD)
                       && ({1'b0, in_word.row_index} < ROW_CNT);
  assign reading     = (state_r == ST_STEP) && (rd_cnt_r < ROW_CNT);
  assign rd_row_data = rd_ok_r ? rd_data_r : '0;
  assign calc_en     = (rd_vld_r && (rd_row_r != '0)) || tail_r;
  assign below       = tail_r ? '0 : rd_row_data;
  assign row_chg     = (fresh != cur_old_r);

  // row update logic
  lgru_row_calc u_row_calc (
    .above    (prev_new_r),
    .old_row  (cur_old_r),
    .below    (below),
    .row_mask (ROW_MASK),
    .fresh    (fresh)
  );

  // write port: step write-back has the port while busy, loads while idle
  always_comb begin
    mem_we    = calc_en || load_we;
    mem_waddr = calc_en ? cmp_row_r : in_word.row_index;
    mem_wdata = calc_en ? fresh : (in_word.row_cells & ROW_MASK);
  end

  // row memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_cnt_r[ROW_AW-1:0]];
  end

  // sequencer, row window and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_cnt_r    <= '0;
      rd_vld_r    <= 1'b0;
      rd_row_r    <= '0;
      tail_r      <= 1'b0;
      rd_ok_r     <= 1'b0;
      cmp_row_r   <= '0;
      chg_r       <= 1'b0;
      row_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r    <= reading;
      rd_row_r    <= rd_cnt_r[ROW_AW-1:0];
      rd_ok_r     <= row_vld_r[rd_cnt_r[ROW_AW-1:0]];
      tail_r      <= rd_vld_r && (rd_row_r == LAST_ROW);
      out_valid_r <= calc_en;
      if (mem_we) begin
        row_vld_r[mem_waddr] <= 1'b1;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept && (in_word.kind == KIND_STEP)) begin
            state_r   <= ST_STEP;
            rd_cnt_r  <= '0;
            cmp_row_r <= '0;
            chg_r     <= 1'b0;
          end
        end
        ST_STEP: begin
          if (reading) begin
            rd_cnt_r <= rd_cnt_r + 1'b1;
          end
          if (tail_r) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
      if (calc_en) begin
        cmp_row_r <= cmp_row_r + 1'b1;
        chg_r     <= chg_r || row_chg;
      end
    end
  end

  // row window payload
  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      cur_old_r <= rd_row_data;
    end
    if (rd_vld_r && (rd_row_r == '0)) begin
      prev_new_r <= '0;
    end else if (calc_en) begin
      prev_new_r <= fresh;
    end
    if (calc_en) begin
      out_word_r.out_row     <= cmp_row_r;
      out_word_r.out_cells   <= fresh;
      out_word_r.last_row    <= tail_r;
      out_word_r.any_changed <= tail_r && (chg_r || row_chg);
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire
